// ----- design/qau_pkg.sv -----
`default_nettype none

package qau_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 27;
   localparam int TOL_W      = 28;
   localparam int NORM_W     = 31;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int HSUM_W     = PROD_W + 2;
   localparam int SQ_W       = PROD_W;
   localparam int RAW_W      = DATA_W + 8;
   localparam int NUM_W      = DATA_W + 1;
   localparam int SQQ_W      = SQ_W - FRAC_W + 1;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int MAG_W      = ROOT_W + 1;
   localparam int DEN_W      = SQQ_W;
   localparam int QUO_W      = DATA_W;
   localparam int NUMER_W    = DATA_W + FRAC_W;
   localparam int LANES      = 4;

   localparam int REQ_DATA_W = 9 * DATA_W;
   localparam int REQ_USER_W = 4;
   localparam int SOS_LSB    = LANES * DATA_W;
   localparam int MAG_LSB    = SOS_LSB + NORM_W;
   localparam int UNIT_BIT   = MAG_LSB + NORM_W;
   localparam int STAT_LSB   = UNIT_BIT + 1;
   localparam int RSP_BITS   = STAT_LSB + 2;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(134);

   typedef enum logic [3:0] {
      CMD_MUL       = 4'd0,
      CMD_ADD       = 4'd1,
      CMD_SUB       = 4'd2,
      CMD_SCALE     = 4'd3,
      CMD_DIVIDE    = 4'd4,
      CMD_CONJ      = 4'd5,
      CMD_INVERT    = 4'd6,
      CMD_NORMALIZE = 4'd7,
      CMD_NORM      = 4'd8,
      CMD_DERIV     = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK  = 2'd0,
      STATUS_SAT = 2'd1,
      STATUS_DZ  = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                         cmd;
      logic [LANES-1:0][RAW_W-1:0]     raw;
      logic [LANES-1:0][NUM_W-1:0]     num;
      logic [DATA_W-1:0]               k;
      logic [SQQ_W-1:0]                s_q;
      logic [NORM_W-1:0]               sos;
      logic [NORM_W-1:0]               mag;
      logic                            unit;
      logic                            ovf;
      logic                            dz;
      logic                            use_div;
      logic                            den_neg;
   } pay_type;

   typedef struct packed {
      logic [SQ_W-1:0]   rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      pay_type           pay;
   } sqrt_stage_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] nq;
      logic             neg;
      logic             povf;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [LANES-1:0] lane;
      logic [DEN_W-1:0]         den;
      pay_type                  pay;
   } div_stage_type;

endpackage

`default_nettype wire

// ----- design/qau_front.sv -----
`default_nettype none

module qau_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic [qau_pkg::REQ_USER_W-1:0]     in_user,
   input  logic [qau_pkg::REQ_DATA_W-1:0]     in_data,
   output logic                               out_valid,
   output qau_pkg::sqrt_stage_type            out_stage
);

   localparam int DW = qau_pkg::DATA_W;
   localparam int NL = qau_pkg::LANES;
   localparam logic signed [qau_pkg::HSUM_W-1:0] RND_F  =
      qau_pkg::HSUM_W'(1) <<< (qau_pkg::FRAC_W - 1);
   localparam logic signed [qau_pkg::HSUM_W-1:0] RND_F1 =
      qau_pkg::HSUM_W'(1) <<< qau_pkg::FRAC_W;

   logic [NL-1:0][DW-1:0] a, b, x, y;
   logic [DW-1:0]         k;
   qau_pkg::cmd_type      cmd;

   logic signed [qau_pkg::PROD_W-1:0] prod_in [NL][NL];
   logic signed [qau_pkg::PROD_W-1:0] prod_a_ff [NL][NL];
   qau_pkg::cmd_type                  cmd_a_ff;
   logic [NL-1:0][DW-1:0]             a_a_ff, b_a_ff;
   logic [DW-1:0]                     k_a_ff;
   logic                              vld_a_ff;

   logic signed [qau_pkg::HSUM_W-1:0] hsum_in [NL];
   logic signed [qau_pkg::HSUM_W-1:0] hsum_b_ff [NL];
   logic signed [qau_pkg::PROD_W-1:0] diag_b_ff [NL];
   logic [qau_pkg::SQ_W:0]            sq_in, sq_b_ff;
   logic signed [qau_pkg::NUM_W-1:0]  conj_v [NL];
   logic signed [qau_pkg::NUM_W-1:0]  simple_in [NL];
   logic signed [qau_pkg::NUM_W-1:0]  simple_b_ff [NL];
   logic signed [qau_pkg::NUM_W-1:0]  num_in [NL];
   logic signed [qau_pkg::NUM_W-1:0]  num_b_ff [NL];
   logic [DW-1:0]                     k_b_ff;
   qau_pkg::cmd_type                  cmd_b_ff;
   logic                              vld_b_ff;

   logic signed [qau_pkg::HSUM_W-1:0] sh_mul [NL];
   logic signed [qau_pkg::HSUM_W-1:0] sh_der [NL];
   logic signed [qau_pkg::HSUM_W-1:0] sh_scl [NL];
   logic [qau_pkg::SQ_W-1:0]          s64;
   qau_pkg::sqrt_stage_type           c_in, c_ff;
   logic                              vld_c_ff;

   always_comb begin
      a   = in_data[NL*DW-1:0];
      b   = in_data[2*NL*DW-1:NL*DW];
      k   = in_data[2*NL*DW+DW-1:2*NL*DW];
      cmd = qau_pkg::cmd_type'(in_user);
      x   = a;
      y   = a;
      unique case (cmd)
         qau_pkg::CMD_MUL: y = b;
         qau_pkg::CMD_SCALE: y = {NL{k}};
         qau_pkg::CMD_DERIV: begin
            x = b;
            y = a;
         end
         default: ;
      endcase
      for (int i = 0; i < NL; i++) begin
         for (int j = 0; j < NL; j++) begin
            prod_in[i][j] = $signed(x[i]) * $signed(y[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
               prod_a_ff[i][j] <= prod_in[i][j];
            end
         end
         cmd_a_ff <= cmd;
         a_a_ff   <= a;
         b_a_ff   <= b;
         k_a_ff   <= k;
      end
   end

   always_comb begin
      hsum_in[0] = qau_pkg::HSUM_W'(prod_a_ff[0][0]) - qau_pkg::HSUM_W'(prod_a_ff[1][1])
                 - qau_pkg::HSUM_W'(prod_a_ff[2][2]) - qau_pkg::HSUM_W'(prod_a_ff[3][3]);
      hsum_in[1] = qau_pkg::HSUM_W'(prod_a_ff[0][1]) + qau_pkg::HSUM_W'(prod_a_ff[1][0])
                 + qau_pkg::HSUM_W'(prod_a_ff[2][3]) - qau_pkg::HSUM_W'(prod_a_ff[3][2]);
      hsum_in[2] = qau_pkg::HSUM_W'(prod_a_ff[0][2]) - qau_pkg::HSUM_W'(prod_a_ff[1][3])
                 + qau_pkg::HSUM_W'(prod_a_ff[2][0]) + qau_pkg::HSUM_W'(prod_a_ff[3][1]);
      hsum_in[3] = qau_pkg::HSUM_W'(prod_a_ff[0][3]) + qau_pkg::HSUM_W'(prod_a_ff[1][2])
                 - qau_pkg::HSUM_W'(prod_a_ff[2][1]) + qau_pkg::HSUM_W'(prod_a_ff[3][0]);
      sq_in = (qau_pkg::SQ_W+1)'($unsigned(prod_a_ff[0][0]))
            + (qau_pkg::SQ_W+1)'($unsigned(prod_a_ff[1][1]))
            + (qau_pkg::SQ_W+1)'($unsigned(prod_a_ff[2][2]))
            + (qau_pkg::SQ_W+1)'($unsigned(prod_a_ff[3][3]));
      for (int i = 0; i < NL; i++) begin
         conj_v[i] = (i == 0) ? qau_pkg::NUM_W'($signed(a_a_ff[i]))
                              : -qau_pkg::NUM_W'($signed(a_a_ff[i]));
         num_in[i] = (cmd_a_ff == qau_pkg::CMD_INVERT) ? conj_v[i]
                                                       : qau_pkg::NUM_W'($signed(a_a_ff[i]));
         case (cmd_a_ff) inside
            qau_pkg::CMD_ADD: simple_in[i] = qau_pkg::NUM_W'($signed(a_a_ff[i]))
                                           + qau_pkg::NUM_W'($signed(b_a_ff[i]));
            qau_pkg::CMD_SUB: simple_in[i] = qau_pkg::NUM_W'($signed(a_a_ff[i]))
                                           - qau_pkg::NUM_W'($signed(b_a_ff[i]));
            qau_pkg::CMD_CONJ, qau_pkg::CMD_INVERT: simple_in[i] = conj_v[i];
            default: simple_in[i] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NL; i++) begin
            hsum_b_ff[i]   <= hsum_in[i];
            diag_b_ff[i]   <= prod_a_ff[i][i];
            simple_b_ff[i] <= simple_in[i];
            num_b_ff[i]    <= num_in[i];
         end
         sq_b_ff  <= sq_in;
         k_b_ff   <= k_a_ff;
         cmd_b_ff <= cmd_a_ff;
      end
   end

   always_comb begin
      s64 = sq_b_ff[qau_pkg::SQ_W] ? '1 : sq_b_ff[qau_pkg::SQ_W-1:0];
      c_in = '0;
      c_in.rad = s64;
      c_in.pay.cmd = cmd_b_ff;
      c_in.pay.k = k_b_ff;
      c_in.pay.s_q = qau_pkg::SQQ_W'(s64 >> qau_pkg::FRAC_W)
                   + qau_pkg::SQQ_W'(s64[qau_pkg::FRAC_W-1]);
      for (int i = 0; i < NL; i++) begin
         sh_mul[i] = (hsum_b_ff[i] + RND_F) >>> qau_pkg::FRAC_W;
         sh_der[i] = (hsum_b_ff[i] + RND_F1) >>> (qau_pkg::FRAC_W + 1);
         sh_scl[i] = (qau_pkg::HSUM_W'(diag_b_ff[i]) + RND_F) >>> qau_pkg::FRAC_W;
         c_in.pay.num[i] = num_b_ff[i];
         case (cmd_b_ff)
            qau_pkg::CMD_MUL:   c_in.pay.raw[i] = sh_mul[i][qau_pkg::RAW_W-1:0];
            qau_pkg::CMD_DERIV: c_in.pay.raw[i] = sh_der[i][qau_pkg::RAW_W-1:0];
            qau_pkg::CMD_SCALE: c_in.pay.raw[i] = sh_scl[i][qau_pkg::RAW_W-1:0];
            default:            c_in.pay.raw[i] = qau_pkg::RAW_W'(simple_b_ff[i]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else if (adv) begin
         vld_a_ff <= in_valid;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
      end
   end

   assign out_valid = vld_c_ff;
   assign out_stage = c_ff;

endmodule

`default_nettype wire

// ----- design/qau_sqrt.sv -----
`default_nettype none

module qau_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  qau_pkg::sqrt_stage_type  in_stage,
   output logic                     out_valid,
   output qau_pkg::sqrt_stage_type  out_stage
);

   localparam int DEPTH = qau_pkg::ROOT_W;
   localparam int RW    = qau_pkg::REM_W;
   localparam int SW    = qau_pkg::SQ_W;
   localparam int TW    = qau_pkg::ROOT_W;

   qau_pkg::sqrt_stage_type stg_in [DEPTH];
   qau_pkg::sqrt_stage_type stg_ff [DEPTH];
   logic [DEPTH-1:0]        vld_ff;

   function automatic qau_pkg::sqrt_stage_type sqrt_step(input qau_pkg::sqrt_stage_type s);
      qau_pkg::sqrt_stage_type r;
      logic [RW+1:0]           cur;
      logic [RW+1:0]           trial;
      r     = s;
      cur   = {s.rem, s.rad[SW-1 -: 2]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[SW-3:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = RW'(cur - trial);
         r.root = {s.root[TW-2:0], 1'b1};
      end else begin
         r.rem  = cur[RW-1:0];
         r.root = {s.root[TW-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      stg_in[0] = sqrt_step(in_stage);
      for (int i = 1; i < DEPTH; i++) begin
         stg_in[i] = sqrt_step(stg_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < DEPTH; i++) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[DEPTH-1];
   assign out_stage = stg_ff[DEPTH-1];

endmodule

`default_nettype wire

// ----- design/qau_div.sv -----
`default_nettype none

module qau_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [qau_pkg::TOL_W-1:0]     tol,
   input  logic                          in_valid,
   input  qau_pkg::sqrt_stage_type       in_stage,
   output logic                          out_valid,
   output qau_pkg::div_stage_type        out_stage
);

   localparam int DEPTH = qau_pkg::QUO_W;
   localparam int DW    = qau_pkg::DATA_W;
   localparam int MW    = qau_pkg::MAG_W;
   localparam int NW    = qau_pkg::NORM_W;
   localparam int EW    = qau_pkg::DEN_W;
   localparam int QW    = qau_pkg::QUO_W;
   localparam int UW    = qau_pkg::NUM_W;
   localparam int XW    = qau_pkg::NUMER_W;
   localparam logic [MW:0] ONE_X = (MW+1)'(1) << qau_pkg::FRAC_W;

   logic [MW-1:0]            mag;
   logic [MW:0]              mag_x;
   logic [MW:0]              tol_x;
   logic [DW-1:0]            kmag;
   qau_pkg::div_stage_type   d1_in, d1_ff, d2_in, d2_ff;
   logic                     vld_d1_ff, vld_d2_ff;
   logic [UW-1:0]            nabs [qau_pkg::LANES];
   logic [XW-1:0]            numer [qau_pkg::LANES];
   qau_pkg::div_stage_type   dv_in [DEPTH];
   qau_pkg::div_stage_type   dv_ff [DEPTH];
   logic [DEPTH-1:0]         vld_dv_ff;

   function automatic qau_pkg::div_stage_type div_step(input qau_pkg::div_stage_type s);
      qau_pkg::div_stage_type r;
      logic [EW:0]            t;
      r = s;
      for (int i = 0; i < qau_pkg::LANES; i++) begin
         t = {s.lane[i].rem, s.lane[i].nq[QW-1]};
         r.lane[i].nq = {s.lane[i].nq[QW-2:0], 1'b0};
         if (t >= {1'b0, s.den}) begin
            r.lane[i].rem   = EW'(t - {1'b0, s.den});
            r.lane[i].nq[0] = 1'b1;
         end else begin
            r.lane[i].rem = t[EW-1:0];
         end
      end
      return r;
   endfunction

   always_comb begin
      mag   = MW'(in_stage.root) + MW'(in_stage.rem > {2'b00, in_stage.root});
      mag_x = {1'b0, mag};
      tol_x = (MW+1)'(tol);
      kmag  = in_stage.pay.k[DW-1] ? DW'(-in_stage.pay.k) : in_stage.pay.k;
      d1_in = '0;
      d1_in.pay = in_stage.pay;
      unique case (in_stage.pay.cmd)
         qau_pkg::CMD_DIVIDE: begin
            d1_in.den         = EW'(kmag);
            d1_in.pay.dz      = (in_stage.pay.k == '0);
            d1_in.pay.use_div = (in_stage.pay.k != '0);
            d1_in.pay.den_neg = in_stage.pay.k[DW-1];
         end
         qau_pkg::CMD_INVERT: begin
            d1_in.den         = in_stage.pay.s_q;
            d1_in.pay.use_div = (in_stage.pay.s_q > EW'(tol));
         end
         qau_pkg::CMD_NORMALIZE: begin
            d1_in.den         = EW'(mag);
            d1_in.pay.dz      = (mag == '0);
            d1_in.pay.use_div = (mag != '0);
         end
         qau_pkg::CMD_NORM: begin
            d1_in.pay.sos  = (|in_stage.pay.s_q[EW-1:NW]) ? '1 : in_stage.pay.s_q[NW-1:0];
            d1_in.pay.mag  = (|mag[MW-1:NW]) ? '1 : mag[NW-1:0];
            d1_in.pay.ovf  = (|in_stage.pay.s_q[EW-1:NW]) || (|mag[MW-1:NW]);
            d1_in.pay.unit = (mag_x + tol_x >= ONE_X) && (mag_x <= ONE_X + tol_x);
         end
         default: ;
      endcase
   end

   always_comb begin
      d2_in = d1_ff;
      for (int i = 0; i < qau_pkg::LANES; i++) begin
         nabs[i]  = d1_ff.pay.num[i][UW-1] ? UW'(-d1_ff.pay.num[i]) : d1_ff.pay.num[i];
         numer[i] = {nabs[i][DW-1:0], qau_pkg::FRAC_W'(0)} + XW'(d1_ff.den >> 1);
         d2_in.lane[i].rem  = EW'(numer[i][XW-1:QW]);
         d2_in.lane[i].nq   = numer[i][QW-1:0];
         d2_in.lane[i].neg  = d1_ff.pay.num[i][UW-1] ^ d1_ff.pay.den_neg;
         d2_in.lane[i].povf = EW'(numer[i][XW-1:QW]) >= d1_ff.den;
      end
   end

   always_comb begin
      dv_in[0] = div_step(d2_ff);
      for (int i = 1; i < DEPTH; i++) begin
         dv_in[i] = div_step(dv_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         for (int i = 0; i < DEPTH; i++) begin
            dv_ff[i] <= dv_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d1_ff <= 1'b0;
         vld_d2_ff <= 1'b0;
         vld_dv_ff <= '0;
      end else if (adv) begin
         vld_d1_ff <= in_valid;
         vld_d2_ff <= vld_d1_ff;
         vld_dv_ff <= {vld_dv_ff[DEPTH-2:0], vld_d2_ff};
      end
   end

   assign out_valid = vld_dv_ff[DEPTH-1];
   assign out_stage = dv_ff[DEPTH-1];

endmodule

`default_nettype wire

// ----- design/qau_back.sv -----
`default_nettype none

module qau_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  qau_pkg::div_stage_type            in_stage,
   output logic                              adv,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [qau_pkg::RSP_DATA_W-1:0]    out_data
);

   localparam int DW = qau_pkg::DATA_W;
   localparam int RW = qau_pkg::RAW_W;
   localparam logic signed [RW-1:0] OVER_POS = RW'(1) <<< DW;
   localparam logic signed [RW-1:0] SAT_MAX  = (RW'(1) <<< (DW - 1)) - RW'(1);
   localparam logic signed [RW-1:0] SAT_MIN  = -(RW'(1) <<< (DW - 1));

   logic signed [RW-1:0]              wide [qau_pkg::LANES];
   logic signed [qau_pkg::NUM_W-1:0]  qs [qau_pkg::LANES];
   logic [qau_pkg::LANES-1:0]         sat_hi, sat_lo;
   logic [qau_pkg::LANES-1:0][DW-1:0] res;
   qau_pkg::status_type               status;
   logic [qau_pkg::RSP_DATA_W-1:0]    data_in, data_ff;
   logic                              valid_ff;

   always_comb begin
      for (int i = 0; i < qau_pkg::LANES; i++) begin
         qs[i] = in_stage.lane[i].neg ? -$signed({1'b0, in_stage.lane[i].nq})
                                      : $signed({1'b0, in_stage.lane[i].nq});
         if (!in_stage.pay.use_div) begin
            wide[i] = $signed(in_stage.pay.raw[i]);
         end else if (in_stage.lane[i].povf) begin
            wide[i] = in_stage.lane[i].neg ? -OVER_POS : OVER_POS;
         end else begin
            wide[i] = RW'(qs[i]);
         end
         sat_hi[i] = !in_stage.pay.dz && (wide[i] > SAT_MAX);
         sat_lo[i] = !in_stage.pay.dz && (wide[i] < SAT_MIN);
         if (in_stage.pay.dz) begin
            res[i] = '0;
         end else if (sat_hi[i]) begin
            res[i] = SAT_MAX[DW-1:0];
         end else if (sat_lo[i]) begin
            res[i] = SAT_MIN[DW-1:0];
         end else begin
            res[i] = wide[i][DW-1:0];
         end
      end
      if (in_stage.pay.dz) begin
         status = qau_pkg::STATUS_DZ;
      end else if ((|sat_hi) || (|sat_lo) || in_stage.pay.ovf) begin
         status = qau_pkg::STATUS_SAT;
      end else begin
         status = qau_pkg::STATUS_OK;
      end
      data_in = qau_pkg::RSP_DATA_W'({status, in_stage.pay.unit, in_stage.pay.mag,
                                      in_stage.pay.sos, res});
   end

   assign adv = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- design/quaternion_arithmetic_unit_core.sv -----
// Channel   Direction  Ports                              Contents
// req       in         req_tvalid/tready/tdata/tuser      one command and its operands
// rsp       out        rsp_tvalid/tready/tdata            one result word
// csr       in         csr_valid/csr_ready/csr_wdata      unit_tolerance write
//
// One word enters per cycle while rsp is not stalled, and each word passes through
// three front stages, the 32-stage square root pipeline, two divider set-up
// stages, the 32-stage restoring divider and the output register.
// Reset is synchronous and clears all valid bits and sets the tolerance to 134.
// A stall on rsp freezes the whole pipeline together with the output register.

`default_nettype none

module quaternion_arithmetic_unit_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar_k
   input  logic [qau_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  logic [qau_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // r_w, r_x, r_y, r_z, sum_of_squares, magnitude, is_unit, status, zero fill
   output logic [qau_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qau_pkg::TOL_W-1:0]         csr_wdata
);

   logic                      adv;
   logic [qau_pkg::TOL_W-1:0] tol_ff;
   logic                      front_valid, sqrt_valid, div_valid;
   qau_pkg::sqrt_stage_type   front_stage, sqrt_stage;
   qau_pkg::div_stage_type    div_stage;

   assign csr_ready  = 1'b1;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= qau_pkg::TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_wdata;
      end
   end

   qau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_user   (req_tuser),
      .in_data   (req_tdata),
      .out_valid (front_valid),
      .out_stage (front_stage)
   );

   qau_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_stage  (front_stage),
      .out_valid (sqrt_valid),
      .out_stage (sqrt_stage)
   );

   qau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .tol       (tol_ff),
      .in_valid  (sqrt_valid),
      .in_stage  (sqrt_stage),
      .out_valid (div_valid),
      .out_stage (div_stage)
   );

   qau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_stage  (div_stage),
      .adv       (adv),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[qau_pkg::STAT_LSB +: 2] == qau_pkg::STATUS_DZ)
      |-> (rsp_tdata[qau_pkg::SOS_LSB-1:0] == '0))
      else $error("Divide by zero result carries a nonzero quaternion.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[qau_pkg::SOS_LSB +: 2*qau_pkg::NORM_W+1] != '0)
      |-> (rsp_tdata[qau_pkg::SOS_LSB-1:0] == '0)
          && (rsp_tdata[qau_pkg::STAT_LSB +: 2] != qau_pkg::STATUS_DZ))
      else $error("Norm outputs appear together with a quaternion result.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[qau_pkg::UNIT_BIT]
      |-> ((34'(rsp_tdata[qau_pkg::MAG_LSB +: qau_pkg::NORM_W]) + 34'(tol_ff)
            >= (34'(1) << qau_pkg::FRAC_W))
          && (34'(rsp_tdata[qau_pkg::MAG_LSB +: qau_pkg::NORM_W])
            <= (34'(1) << qau_pkg::FRAC_W) + 34'(tol_ff))))
      else $error("Unit flag set with a magnitude outside the tolerance band.");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import qau_pkg::*;

   localparam int LAT = 72;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [31:0] r [4];
      logic [30:0] sos;
      logic [30:0] mag;
      logic        unit;
      logic [1:0]  status;
   } quat_result_t;

   class quat_scoreboard;
      quat_result_t pending[$];
      longint unsigned tol;
      int errors;
      int checked;

      function new();
         tol = 134;
         errors = 0;
         checked = 0;
      endfunction

      function automatic logic signed [71:0] round_shift(logic signed [71:0] v, int s);
         logic signed [71:0] half;
         half = 72'sd1 <<< (s - 1);
         return (v + half) >>> s;
      endfunction

      function automatic void hamilton(longint p[4], longint q[4], int s,
                                       ref logic signed [71:0] r[4]);
         r[0] = round_shift(72'(p[0]*q[0]) - 72'(p[1]*q[1]) - 72'(p[2]*q[2])
                            - 72'(p[3]*q[3]), s);
         r[1] = round_shift(72'(p[0]*q[1]) + 72'(p[1]*q[0]) + 72'(p[2]*q[3])
                            - 72'(p[3]*q[2]), s);
         r[2] = round_shift(72'(p[0]*q[2]) - 72'(p[1]*q[3]) + 72'(p[2]*q[0])
                            + 72'(p[3]*q[1]), s);
         r[3] = round_shift(72'(p[0]*q[3]) + 72'(p[1]*q[2]) - 72'(p[2]*q[1])
                            + 72'(p[3]*q[0]), s);
      endfunction

      function automatic longint quotient(longint num, longint den);
         longint unsigned n, d, q;
         n = longint'(num < 0 ? -num : num) << FRAC_W;
         d = den < 0 ? -den : den;
         q = (n + d / 2) / d;
         return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
      endfunction

      function automatic longint unsigned square_sum(longint a[4]);
         logic [65:0] acc;
         acc = 0;
         for (int i = 0; i < 4; i++) begin
            acc += 66'(a[i] * a[i]);
         end
         return (acc > 66'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
      endfunction

      function automatic longint unsigned root_rounded(longint unsigned x);
         longint unsigned r, bitv, v;
         r = 0;
         v = x;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= r + bitv) begin
               v -= r + bitv;
               r = (r >> 1) + bitv;
            end else begin
               r >>= 1;
            end
            bitv >>= 2;
         end
         if (x - r * r > r) r++;
         return r;
      endfunction

      function automatic longint unsigned to_q(longint unsigned s);
         return (s >> FRAC_W) + ((s >> (FRAC_W - 1)) & 1);
      endfunction

      function automatic quat_result_t predict(logic [3:0] cmd, logic [31:0] ops[9]);
         quat_result_t e;
         longint a[4], b[4], c[4], k;
         logic signed [71:0] r[4];
         longint unsigned s, m;
         logic signed [71:0] hi, lo;
         bit ovf, dz;
         ovf = 0;
         dz = 0;
         for (int i = 0; i < 4; i++) begin
            a[i] = longint'($signed(ops[i]));
            b[i] = longint'($signed(ops[4+i]));
            c[i] = (i == 0) ? a[i] : -a[i];
            r[i] = 0;
         end
         k = longint'($signed(ops[8]));
         e.sos = 0;
         e.mag = 0;
         e.unit = 0;
         case (cmd)
            CMD_MUL:    hamilton(a, b, FRAC_W, r);
            CMD_ADD:    for (int i = 0; i < 4; i++) r[i] = 72'(a[i] + b[i]);
            CMD_SUB:    for (int i = 0; i < 4; i++) r[i] = 72'(a[i] - b[i]);
            CMD_SCALE:  for (int i = 0; i < 4; i++) r[i] = round_shift(72'(a[i] * k), FRAC_W);
            CMD_DIVIDE: begin
               if (k == 0) dz = 1;
               else for (int i = 0; i < 4; i++) r[i] = 72'(quotient(a[i], k));
            end
            CMD_CONJ:   for (int i = 0; i < 4; i++) r[i] = 72'(c[i]);
            CMD_INVERT: begin
               s = to_q(square_sum(a));
               for (int i = 0; i < 4; i++)
                  r[i] = (s > tol) ? 72'(quotient(c[i], longint'(s))) : 72'(c[i]);
            end
            CMD_NORMALIZE: begin
               m = root_rounded(square_sum(a));
               if (m == 0) dz = 1;
               else for (int i = 0; i < 4; i++) r[i] = 72'(quotient(a[i], longint'(m)));
            end
            CMD_NORM: begin
               s = square_sum(a);
               m = root_rounded(s);
               s = to_q(s);
               e.unit = (longint'(m) >= (longint'(1) << FRAC_W) - longint'(tol)) &&
                        (longint'(m) <= (longint'(1) << FRAC_W) + longint'(tol));
               if (s > 64'h7FFF_FFFF) begin s = 64'h7FFF_FFFF; ovf = 1; end
               if (m > 64'h7FFF_FFFF) begin m = 64'h7FFF_FFFF; ovf = 1; end
               e.sos = s[30:0];
               e.mag = m[30:0];
            end
            CMD_DERIV:  hamilton(b, a, FRAC_W + 1, r);
            default: ;
         endcase
         hi = 72'sd2147483647;
         lo = -72'sd2147483648;
         for (int i = 0; i < 4; i++) begin
            if (dz) r[i] = 0;
            else if (r[i] > hi) begin r[i] = hi; ovf = 1; end
            else if (r[i] < lo) begin r[i] = lo; ovf = 1; end
            e.r[i] = r[i][31:0];
         end
         e.status = dz ? STATUS_DZ : (ovf ? STATUS_SAT : STATUS_OK);
         return e;
      endfunction

      function void note(logic [3:0] cmd, logic [31:0] ops[9]);
         pending.push_back(predict(cmd, ops));
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch on %s: got %h, expected %h", what, got, want);
         errors++;
      endtask

      task check(logic [RSP_DATA_W-1:0] word);
         quat_result_t e;
         checked++;
         if (pending.size() == 0) begin
            report("unexpected word", 64'(word[63:0]), 0);
            return;
         end
         e = pending.pop_front();
         for (int i = 0; i < 4; i++)
            if (word[32*i +: 32] !== e.r[i]) report("result lane", word[32*i +: 32], e.r[i]);
         if (word[SOS_LSB +: NORM_W] !== e.sos)
            report("sum_of_squares", word[SOS_LSB +: NORM_W], e.sos);
         if (word[MAG_LSB +: NORM_W] !== e.mag)
            report("magnitude", word[MAG_LSB +: NORM_W], e.mag);
         if (word[UNIT_BIT] !== e.unit) report("is_unit", word[UNIT_BIT], e.unit);
         if (word[STAT_LSB +: 2] !== e.status) report("status", word[STAT_LSB +: 2], e.status);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [TOL_W-1:0] csr_wdata = '0;

   quat_scoreboard quat_sb = new();
   int idle_cycles = 0;
   int unsigned cycle_count = 0;
   int cmd_seen[16];

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   quaternion_arithmetic_unit_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count >> 9) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= (cycle_count % 5) == 0;
         default: rsp_tready <= ($urandom_range(0, 9) != 0);
      endcase
      if (!reset && rsp_tvalid && rsp_tready) quat_sb.check(rsp_tdata);
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                     (csr_valid && csr_ready)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d words outstanding", quat_sb.pending.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task send_word(logic [3:0] cmd, logic [31:0] ops[9]);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      for (int i = 0; i < 9; i++) req_tdata[32*i +: 32] <= ops[i];
      do @(posedge clock); while (!req_tready);
      quat_sb.note(cmd, ops);
      cmd_seen[cmd]++;
   endtask

   task pause(int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task write_tolerance(logic [TOL_W-1:0] value);
      pause(1);
      while (quat_sb.pending.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      quat_sb.tol = value;
   endtask

   function automatic logic [31:0] pick_value(int style);
      case (style)
         0: return $urandom;
         1: return 32'(32'sd67108864 * ($urandom_range(0, 1) ? 1 : -1)
                       + $signed(32'($urandom_range(0, 400)) - 32'sd200));
         2: return 32'($signed(32'($urandom_range(0, 32768)) - 32'sd16384));
         3: return 32'($signed(32'($urandom_range(0, 1 << 28)) - 32'sd134217728));
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'h0800_0000;
            endcase
         end
      endcase
   endfunction

   task send_random();
      logic [31:0] ops[9];
      logic [3:0] cmd;
      int style;
      cmd = ($urandom_range(0, 40) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      style = $urandom_range(0, 4);
      for (int i = 0; i < 9; i++)
         ops[i] = pick_value($urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : style);
      if (cmd == CMD_DIVIDE && $urandom_range(0, 7) == 0) ops[8] = 0;
      if ((cmd == CMD_NORMALIZE || cmd == CMD_INVERT) && $urandom_range(0, 9) == 0)
         for (int i = 0; i < 4; i++) ops[i] = $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : 0;
      send_word(cmd, ops);
   endtask

   task run_random(int count);
      int left;
      left = count;
      while (left > 0) begin
         for (int n = $urandom_range(1, 24); n > 0 && left > 0; n--) begin
            send_random();
            left--;
         end
         pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
      end
   endtask

   task run_directed();
      logic [31:0] ops[9];
      logic [31:0] ext[4];
      ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      for (int c = 0; c < 16; c++) begin
         for (int i = 0; i < 9; i++) ops[i] = ext[(c + i) % 4];
         send_word(4'(c), ops);
      end
      for (int i = 0; i < 9; i++) ops[i] = 32'h8000_0000;
      send_word(CMD_NORM, ops);
      send_word(CMD_INVERT, ops);
      ops = '{32'h0800_0000, 0, 0, 0, 32'h0800_0000, 0, 0, 0, 0};
      send_word(CMD_DIVIDE, ops);
      send_word(CMD_NORM, ops);
      ops = '{0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0001};
      send_word(CMD_NORMALIZE, ops);
      ops = '{32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0003, 0, 0, 0, 0, 0, 1};
      send_word(CMD_INVERT, ops);
      send_word(CMD_DIVIDE, ops);
      ops = '{32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 0, 0, 0, 0, 0};
      send_word(CMD_INVERT, ops);
      pause(1);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(250);
      write_tolerance(28'd0);
      run_directed();
      run_random(250);
      write_tolerance(28'd134217728);
      run_random(250);
      write_tolerance(28'($urandom_range(0, 1 << 20)));
      run_random(250);
      write_tolerance(28'($urandom_range(0, 134217728)));
      run_random(200);
      write_tolerance(28'd134);
      run_random(100);
      pause(1);
      while (quat_sb.pending.size() != 0) @(posedge clock);
      repeat (LAT + 20) @(posedge clock);
      $display("Checked %0d result words over six tolerance settings.", quat_sb.checked);
      $display("Commands mul..deriv seen: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
               cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4],
               cmd_seen[5], cmd_seen[6], cmd_seen[7], cmd_seen[8], cmd_seen[9]);
      if (quat_sb.errors == 0 && quat_sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
